// File: hdl/lpi_pkg.sv
// ----------------------------------------------------------------------------
// lpi_pkg
// Shared types and constants of the line pair intersection block.
// ----------------------------------------------------------------------------
`default_nettype none

package lpi_pkg;

    localparam int COEF_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUOT_BITS      = 32;
    localparam int OUT_FRAC       = 16;
    localparam int M_DATA_W       = 72;
    localparam int CT_W           = 15;
    localparam int DT_W           = 31;
    localparam int APB_ADDR_W     = 3;

    // outcome codes
    typedef enum logic [2:0] {
        OUT_UNIQUE     = 3'd0,
        OUT_ORIGIN     = 3'd1,
        OUT_COINCIDENT = 3'd2,
        OUT_DISJOINT   = 3'd3,
        OUT_NO_NORMAL  = 3'd4
    } outcome_t;

    // register indexes (paddr[2])
    typedef enum logic {
        REG_COEF_THR = 1'b0,
        REG_DET_THR  = 1'b1
    } reg_idx_t;

    // control of one request between front, queue and back
    typedef struct packed {
        logic     found;
        outcome_t outcome;
        logic     x_zero;
        logic     x_neg;
        logic     y_zero;
        logic     y_neg;
    } ctl_t;

    localparam int CTL_W = $bits(ctl_t);

endpackage

`default_nettype wire

// File: hdl/lpi_front.sv
// ----------------------------------------------------------------------------
// lpi_front
// Forms the products, classifies the line pair and selects divider operands.
// ----------------------------------------------------------------------------
`default_nettype none

module lpi_front #(
    parameter int COEF_WIDTH = lpi_pkg::COEF_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    input  wire logic [6*COEF_WIDTH-1:0]       in_data,
    input  wire logic [lpi_pkg::CT_W-1:0]      coef_thr,
    input  wire logic [lpi_pkg::DT_W-1:0]      det_thr,
    output logic                               busy,
    output logic                               push,
    output lpi_pkg::ctl_t                      push_ctl,
    output logic [2*COEF_WIDTH-1:0]            push_nx,
    output logic [2*COEF_WIDTH-1:0]            push_dx,
    output logic [2*COEF_WIDTH-1:0]            push_ny,
    output logic [2*COEF_WIDTH-1:0]            push_dy
);
    import lpi_pkg::*;

    localparam int CW = COEF_WIDTH;
    localparam int MW = 2 * COEF_WIDTH;
    localparam int XW = (CW + 1 > CT_W) ? CW + 1 : CT_W;
    localparam int DW = (MW > DT_W) ? MW : DT_W;

    logic                 valid_reg;
    logic signed [CW-1:0] anx_reg, any_reg, aof_reg, bnx_reg, bny_reg, bof_reg;
    logic signed [MW-1:0] p_anx_bny_reg, p_any_bnx_reg;
    logic signed [MW-1:0] p_bof_any_reg, p_aof_bny_reg;
    logic signed [MW-1:0] p_bof_anx_reg, p_aof_bnx_reg;

    logic signed [CW-1:0] in_anx, in_any, in_aof, in_bnx, in_bny, in_bof;

    assign in_anx = in_data[0*CW +: CW];
    assign in_any = in_data[1*CW +: CW];
    assign in_aof = in_data[2*CW +: CW];
    assign in_bnx = in_data[3*CW +: CW];
    assign in_bny = in_data[4*CW +: CW];
    assign in_bof = in_data[5*CW +: CW];

    // capture coefficients and their products
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
        end
        if (in_valid) begin
            anx_reg       <= in_anx;
            any_reg       <= in_any;
            aof_reg       <= in_aof;
            bnx_reg       <= in_bnx;
            bny_reg       <= in_bny;
            bof_reg       <= in_bof;
            p_anx_bny_reg <= in_anx * in_bny;
            p_any_bnx_reg <= in_any * in_bnx;
            p_bof_any_reg <= in_bof * in_any;
            p_aof_bny_reg <= in_aof * in_bny;
            p_bof_anx_reg <= in_bof * in_anx;
            p_aof_bnx_reg <= in_aof * in_bnx;
        end
    end

    assign busy = valid_reg;
    assign push = valid_reg;

    // difference of two products as sign and magnitude
    function automatic logic [MW:0] diff_sm(input logic signed [MW-1:0] p,
                                            input logic signed [MW-1:0] q);
        logic signed [MW:0] d;
        logic        [MW:0] m;
        d = {p[MW-1], p} - {q[MW-1], q};
        m = d[MW] ? (~d + 1'b1) : d;
        return {d[MW], m[MW-1:0]};
    endfunction

    function automatic logic [CW:0] abs_c(input logic signed [CW-1:0] v);
        logic [CW:0] e;
        e = {v[CW-1], v};
        return v[CW-1] ? (~e + 1'b1) : e;
    endfunction

    function automatic logic pos_gt(input logic signed [CW-1:0] v,
                                    input logic [CT_W-1:0] t);
        return !v[CW-1] && (XW'(unsigned'(v)) > XW'(t));
    endfunction

    logic [MW:0]   dsm, xsm, ysm;
    logic [MW-1:0] dm, xm, ym;
    logic          dneg, xneg, yneg;
    logic [CW:0]   aof_m, bof_m;
    logic          origin, parallel, far;

    always_comb begin
        dsm  = diff_sm(p_anx_bny_reg, p_any_bnx_reg);
        xsm  = diff_sm(p_bof_any_reg, p_aof_bny_reg);
        ysm  = diff_sm(p_bof_anx_reg, p_aof_bnx_reg);
        dneg = dsm[MW];
        xneg = xsm[MW];
        yneg = ysm[MW];
        dm   = dsm[MW-1:0];
        xm   = xsm[MW-1:0];
        ym   = ysm[MW-1:0];
        aof_m = abs_c(aof_reg);
        bof_m = abs_c(bof_reg);
        origin   = (XW'(aof_m) < XW'(coef_thr)) && (XW'(bof_m) < XW'(coef_thr));
        parallel = (DW'(dm) < DW'(det_thr)) || (dm == '0);
        far      = (DW'(xm) > DW'(det_thr)) || (DW'(ym) > DW'(det_thr));
    end

    // classify and pick divider operands
    always_comb begin
        push_ctl.found   = 1'b0;
        push_ctl.outcome = OUT_NO_NORMAL;
        push_ctl.x_zero  = 1'b1;
        push_ctl.x_neg   = 1'b0;
        push_ctl.y_zero  = 1'b1;
        push_ctl.y_neg   = 1'b0;
        push_nx = '0;
        push_dx = MW'(1);
        push_ny = '0;
        push_dy = MW'(1);
        if (origin) begin
            push_ctl.found   = 1'b1;
            push_ctl.outcome = OUT_ORIGIN;
        end else if (parallel) begin
            if (far) begin
                push_ctl.outcome = OUT_DISJOINT;
            end else if (pos_gt(anx_reg, coef_thr)) begin
                push_ctl.found   = 1'b1;
                push_ctl.outcome = OUT_COINCIDENT;
                push_ctl.x_zero  = 1'b0;
                push_ctl.x_neg   = !aof_reg[CW-1] && (aof_reg != '0);
                push_nx = MW'(aof_m);
                push_dx = MW'(unsigned'(anx_reg));
            end else if (pos_gt(any_reg, coef_thr)) begin
                push_ctl.found   = 1'b1;
                push_ctl.outcome = OUT_COINCIDENT;
                push_ctl.y_zero  = 1'b0;
                push_ctl.y_neg   = !aof_reg[CW-1] && (aof_reg != '0);
                push_ny = MW'(aof_m);
                push_dy = MW'(unsigned'(any_reg));
            end else if (pos_gt(bnx_reg, coef_thr)) begin
                push_ctl.found   = 1'b1;
                push_ctl.outcome = OUT_COINCIDENT;
                push_ctl.x_zero  = 1'b0;
                push_ctl.x_neg   = !bof_reg[CW-1] && (bof_reg != '0);
                push_nx = MW'(bof_m);
                push_dx = MW'(unsigned'(bnx_reg));
            end else if (pos_gt(bny_reg, coef_thr)) begin
                push_ctl.found   = 1'b1;
                push_ctl.outcome = OUT_COINCIDENT;
                push_ctl.y_zero  = 1'b0;
                push_ctl.y_neg   = !bof_reg[CW-1] && (bof_reg != '0);
                push_ny = MW'(bof_m);
                push_dy = MW'(unsigned'(bny_reg));
            end else begin
                push_ctl.outcome = OUT_NO_NORMAL;
            end
        end else begin
            push_ctl.found   = 1'b1;
            push_ctl.outcome = OUT_UNIQUE;
            push_ctl.x_zero  = 1'b0;
            push_ctl.x_neg   = xneg ^ dneg;
            push_ctl.y_zero  = 1'b0;
            push_ctl.y_neg   = !(yneg ^ dneg);
            push_nx = xm;
            push_dx = dm;
            push_ny = ym;
            push_dy = dm;
        end
    end

endmodule

`default_nettype wire

// File: hdl/lpi_queue.sv
// ----------------------------------------------------------------------------
// lpi_queue
// Short request queue between the classifying front and the divider back.
// ----------------------------------------------------------------------------
`default_nettype none

module lpi_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lpi_pkg::QUEUE_DEPTH
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     push,
    input  wire logic [WIDTH-1:0]         push_data,
    input  wire logic                     pop,
    output logic                          pop_valid,
    output logic [WIDTH-1:0]              pop_data,
    output logic [$clog2(DEPTH+1)-1:0]    count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [0:DEPTH-1];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNTW-1:0]  count_reg;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (32'(p) == DEPTH - 1) ? '0 : PW'(p + 1'b1);
    endfunction

    // advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            count_reg <= count_reg + CNTW'(push) - CNTW'(pop);
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

`default_nettype wire

// File: hdl/lpi_back.sv
// ----------------------------------------------------------------------------
// lpi_back
// Pipelined restoring divider for both coordinates, saturation and output.
// ----------------------------------------------------------------------------
`default_nettype none

module lpi_back #(
    parameter int COEF_WIDTH = lpi_pkg::COEF_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_valid,
    input  wire lpi_pkg::ctl_t                 q_ctl,
    input  wire logic [2*COEF_WIDTH-1:0]       q_nx,
    input  wire logic [2*COEF_WIDTH-1:0]       q_dx,
    input  wire logic [2*COEF_WIDTH-1:0]       q_ny,
    input  wire logic [2*COEF_WIDTH-1:0]       q_dy,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [lpi_pkg::M_DATA_W-1:0]       m_tdata
);
    import lpi_pkg::*;

    localparam int MW = 2 * COEF_WIDTH;
    localparam int NS = QUOT_BITS;

    logic                 en;
    logic                 v_reg   [0:NS];
    ctl_t                 ctl_reg [0:NS];
    logic [MW-1:0]        rem_reg [0:NS][0:1];
    logic [MW-1:0]        d_reg   [0:NS][0:1];
    logic [NS-1:0]        low_reg [0:NS][0:1];
    logic [NS-1:0]        q_reg   [0:NS][0:1];
    logic                 ovf_reg [0:NS][0:1];

    logic                 out_valid_reg;
    logic [M_DATA_W-1:0]  out_data_reg;

    logic [MW-1:0]        in_n [0:1];
    logic [MW-1:0]        in_d [0:1];

    // the whole back advances unless a result waits
    assign en    = !out_valid_reg || m_tready;
    assign q_pop = en && q_valid;

    assign in_n[0] = q_nx;
    assign in_d[0] = q_dx;
    assign in_n[1] = q_ny;
    assign in_d[1] = q_dy;

    // load the divider entry, flag quotients beyond 32 bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= q_valid;
        end
        if (en) begin
            ctl_reg[0] <= q_ctl;
            for (int l = 0; l < 2; l++) begin
                rem_reg[0][l] <= MW'(in_n[l] >> OUT_FRAC);
                low_reg[0][l] <= {in_n[l][OUT_FRAC-1:0], {OUT_FRAC{1'b0}}};
                d_reg[0][l]   <= in_d[l];
                q_reg[0][l]   <= '0;
                ovf_reg[0][l] <= {{OUT_FRAC{1'b0}}, in_n[l]} >=
                                 {in_d[l], {OUT_FRAC{1'b0}}};
            end
        end
    end

    // one quotient bit per stage
    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [MW:0] rs   [0:1];
        logic [MW:0] sub  [0:1];
        logic        ge   [0:1];

        always_comb begin
            for (int l = 0; l < 2; l++) begin
                rs[l]  = {rem_reg[k][l], low_reg[k][l][NS-1]};
                sub[l] = rs[l] - {1'b0, d_reg[k][l]};
                ge[l]  = rs[l] >= {1'b0, d_reg[k][l]};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= v_reg[k];
            end
            if (en) begin
                ctl_reg[k+1] <= ctl_reg[k];
                for (int l = 0; l < 2; l++) begin
                    rem_reg[k+1][l] <= ge[l] ? sub[l][MW-1:0] : rs[l][MW-1:0];
                    low_reg[k+1][l] <= {low_reg[k][l][NS-2:0], 1'b0};
                    d_reg[k+1][l]   <= d_reg[k][l];
                    q_reg[k+1][l]   <= {q_reg[k][l][NS-2:0], ge[l]};
                    ovf_reg[k+1][l] <= ovf_reg[k][l];
                end
            end
        end
    end

    // apply sign and clip to the signed 32-bit range
    logic [31:0] coord [0:1];
    logic        csat  [0:1];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            coord[l] = '0;
            csat[l]  = 1'b0;
            if (!(l == 0 ? ctl_reg[NS].x_zero : ctl_reg[NS].y_zero)) begin
                if (l == 0 ? ctl_reg[NS].x_neg : ctl_reg[NS].y_neg) begin
                    csat[l]  = ovf_reg[NS][l] ||
                               (q_reg[NS][l][31] && (q_reg[NS][l][30:0] != '0));
                    coord[l] = csat[l] ? 32'h8000_0000 : (~q_reg[NS][l] + 1'b1);
                end else begin
                    csat[l]  = ovf_reg[NS][l] || q_reg[NS][l][31];
                    coord[l] = csat[l] ? 32'h7FFF_FFFF : q_reg[NS][l];
                end
            end
        end
    end

    // hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= v_reg[NS];
        end
        if (en) begin
            out_data_reg <= M_DATA_W'({csat[0] || csat[1], coord[1], coord[0],
                                       ctl_reg[NS].outcome, ctl_reg[NS].found});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// File: hdl/line_pair_intersection_2d.sv
// ----------------------------------------------------------------------------
// line_pair_intersection_2d
// Intersection of two lines by Cramer's rule, Q16.16 point and outcome code.
// ----------------------------------------------------------------------------
//  Channel   Dir  Group               Contents
//  s_        in   tvalid/tready/tdata a_nx a_ny a_off b_nx b_ny b_off
//  m_        out  tvalid/tready/tdata found outcome point_x point_y saturated
//  apb       in   psel/penable/...    coef_threshold @0x0, det_threshold @0x4
//
//  One item per cycle unless the output stalls; an item passes the front
//  register, a queue slot, the divider entry register, the 32-stage divider
//  pipeline (one quotient bit per stage) and the output register.
//  Reset is synchronous and active low; thresholds return to 1.
//  A stalled output freezes the back; the front keeps taking items until
//  the four-entry request queue is spoken for.
// ----------------------------------------------------------------------------
`default_nettype none

module line_pair_intersection_2d #(
    parameter int COEF_WIDTH = lpi_pkg::COEF_WIDTH_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // a_nx, a_ny, a_off, b_nx, b_ny, b_off (low to high)
    input  wire logic [((6*COEF_WIDTH+7)/8)*8-1:0]      s_tdata,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // found, outcome[2:0], point_x[31:0], point_y[31:0], saturated (low to high)
    output logic [lpi_pkg::M_DATA_W-1:0]                m_tdata,
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [lpi_pkg::APB_ADDR_W-1:0]         paddr,
    input  wire logic [31:0]                            pwdata,
    output logic [31:0]                                 prdata,
    output logic                                        pready
);
    import lpi_pkg::*;

    localparam int MW   = 2 * COEF_WIDTH;
    localparam int QW   = CTL_W + 4 * MW;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    logic [CT_W-1:0] coef_thr_reg;
    logic [DT_W-1:0] det_thr_reg;
    reg_idx_t        widx;

    // register writes
    assign pready = 1'b1;
    assign widx   = reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_thr_reg <= CT_W'(1);
            det_thr_reg  <= DT_W'(1);
        end else if (psel && penable && pwrite) begin
            unique case (widx)
                REG_COEF_THR: coef_thr_reg <= pwdata[CT_W-1:0];
                REG_DET_THR:  det_thr_reg  <= pwdata[DT_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (widx)
            REG_COEF_THR: prdata = 32'(coef_thr_reg);
            REG_DET_THR:  prdata = 32'(det_thr_reg);
            default:      prdata = '0;
        endcase
    end

    logic            front_busy, push, q_valid, q_pop, s_acc;
    ctl_t            push_ctl, q_ctl;
    logic [MW-1:0]   push_nx, push_dx, push_ny, push_dy;
    logic [MW-1:0]   q_nx, q_dx, q_ny, q_dy;
    logic [QW-1:0]   q_data;
    logic [CNTW-1:0] q_count;

    // admit a request only when a queue slot is guaranteed
    assign s_tready = (32'(q_count) + 32'(front_busy)) < QUEUE_DEPTH;
    assign s_acc    = s_tvalid && s_tready;

    lpi_front #(.COEF_WIDTH(COEF_WIDTH)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_acc),
        .in_data  (s_tdata[6*COEF_WIDTH-1:0]),
        .coef_thr (coef_thr_reg),
        .det_thr  (det_thr_reg),
        .busy     (front_busy),
        .push     (push),
        .push_ctl (push_ctl),
        .push_nx  (push_nx),
        .push_dx  (push_dx),
        .push_ny  (push_ny),
        .push_dy  (push_dy)
    );

    lpi_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_ctl, push_nx, push_dx, push_ny, push_dy}),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_data),
        .count     (q_count)
    );

    assign {q_ctl, q_nx, q_dx, q_ny, q_dy} = q_data;

    lpi_back #(.COEF_WIDTH(COEF_WIDTH)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ctl    (q_ctl),
        .q_nx     (q_nx),
        .q_dx     (q_dx),
        .q_ny     (q_ny),
        .q_dy     (q_dy),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// File: hdl/lpi_checker.sv
// ----------------------------------------------------------------------------
// lpi_checker
// Port-level checks on the result channel of the intersection block.
// ----------------------------------------------------------------------------
`default_nettype none

module lpi_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [lpi_pkg::M_DATA_W-1:0]  m_tdata
);
    import lpi_pkg::*;

    logic        found, sat;
    logic [2:0]  oc;
    logic [31:0] px, py;

    assign found = m_tdata[0];
    assign oc    = m_tdata[3:1];
    assign px    = m_tdata[35:4];
    assign py    = m_tdata[67:36];
    assign sat   = m_tdata[68];

    // a waiting result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // found follows the outcome
    a_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (found == (oc == OUT_UNIQUE || oc == OUT_ORIGIN ||
                                oc == OUT_COINCIDENT)))
        else $error("found disagrees with outcome");

    // no point and no clipping without a division
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (oc == OUT_ORIGIN || oc == OUT_DISJOINT || oc == OUT_NO_NORMAL)
        |-> (px == '0 && py == '0 && !sat))
        else $error("point set for an outcome without one");

    // coincident lines give a point on one axis
    a_axis: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && oc == OUT_COINCIDENT |-> (px == '0 || py == '0))
        else $error("coincident point off both axes");

endmodule

bind line_pair_intersection_2d lpi_checker u_lpi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
